[rtl/core/lvsu_pkg.sv]
// Shared types and constants of the lumped volume state update block.
package lvsu_pkg;

  localparam logic [63:0] SIGN_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

  // Request type codes carried on req_type_i.
  localparam logic [2:0] MODE_INLET   = 3'd0;
  localparam logic [2:0] MODE_OUTLET  = 3'd1;
  localparam logic [2:0] MODE_BOTH    = 3'd2;
  localparam logic [2:0] MODE_AIR_IN  = 3'd3;
  localparam logic [2:0] MODE_AIR_OUT = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_VOLUME    = 3'd0;
  localparam logic [2:0] REG_GAMMA     = 3'd1;
  localparam logic [2:0] REG_OFFSET    = 3'd2;
  localparam logic [2:0] REG_INIT_RHO  = 3'd3;
  localparam logic [2:0] REG_INIT_PRES = 3'd4;

  // Reset values of the registers and state, Q32.32.
  localparam logic [62:0] RST_VOLUME    = 63'd4294967296;
  localparam logic [62:0] RST_GAMMA     = 63'd6012954214;
  localparam logic [63:0] RST_OFFSET    = 64'd0;
  localparam logic [62:0] RST_INIT_RHO  = 63'd4294967296;
  localparam logic [63:0] RST_INIT_PRES = 64'd4294967296;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } alu_rsp_t;

endpackage

[rtl/core/lumped_volume_state_update.sv]
// Top level of the lumped compressible volume node: one time step per transfer.
// Operation: multiplies, divides and square roots all run in sequence on one bit-serial
// unit; an unused request code goes straight to the result state with no operation.
// Throughput: one item at a time; the input stalls until the result has been taken.
// Reset: asynchronous, active low; registers and state return to their reset values.
module lumped_volume_state_update import lvsu_pkg::*; #(
  parameter int FRAC_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [63:0] outlet_density_i,
  input  logic [63:0] outlet_flow_i,
  input  logic [63:0] inlet_density_i,
  input  logic [63:0] inlet_flow_i,
  input  logic [62:0] time_step_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] density_out_o,
  output logic [63:0] pressure_out_o,
  output logic [62:0] sound_speed_out_o,
  output logic [63:0] stable_step_o,
  output logic        saturated_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // At or below this magnitude of omega the stable step is reported as a fixed cap.
  localparam logic [63:0] OMEGA_MIN = (64'd1 << FRAC_BITS) / 64'd1000000;
  localparam logic [63:0] ONE_FX    = 64'd1 << FRAC_BITS;
  localparam logic [63:0] STAB_CAP  = (FRAC_BITS <= 46) ? (64'd100000 << FRAC_BITS) : POS_MAX;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_NUM,
    ST_CDIV,
    ST_CSQRT,
    ST_C2,
    ST_FX,
    ST_FY,
    ST_FDIV,
    ST_OMEGA,
    ST_DRHO,
    ST_DP,
    ST_STAB,
    ST_AR1,
    ST_AR2,
    ST_AR3,
    ST_AP1,
    ST_AP2,
    ST_AP3,
    ST_AP4,
    ST_OUT
  } state_e;

  state_e      st_q;
  logic        issued_q;
  logic        sat_q;

  // Configuration registers.
  logic [62:0] vol_q;
  logic [62:0] gamma_q;
  logic [63:0] boff_q;
  logic [62:0] init_rho_q;
  logic [63:0] init_pres_q;

  // Node state.
  logic [63:0] rho_q;
  logic [63:0] pres_q;
  logic [63:0] snd_q;

  // Captured item and intermediate values.
  logic [2:0]  mode_q;
  logic [63:0] rho_o_q;
  logic [63:0] q_o_q;
  logic [63:0] rho_i_q;
  logic [63:0] q_i_q;
  logic [62:0] dt_q;
  logic [63:0] t0_q;
  logic [63:0] t1_q;
  logic [63:0] c2_q;
  logic [63:0] f_q;
  logic [63:0] om_q;
  logic [63:0] stab_q;

  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;
  logic [63:0] alu_a;
  logic [63:0] alu_b;
  logic [63:0] alu_res;

  logic        cfg_wr;
  logic        in_xfer;
  logic        sub_mode;
  logic        working;
  logic [64:0] num_add;
  logic [64:0] fy_sub;
  logic [63:0] rho_arg;
  logic [64:0] rho_upd;
  logic [64:0] pres_upd;
  logic        extra_sat;
  logic [63:0] om_mag;

  // Saturating signed sum and difference; the top bit flags a clamp.
  function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) return {1'b1, a[63] ? SIGN_MIN : POS_MAX};
    return {1'b0, r};
  endfunction

  function automatic logic [64:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) return {1'b1, a[63] ? SIGN_MIN : POS_MAX};
    return {1'b0, r};
  endfunction

  lvsu_alu #(
    .FRAC_BITS(FRAC_BITS)
  ) u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .rsp_o (alu_rsp),
    .res_o (alu_res)
  );

  assign cfg_wr      = psel && penable && pwrite;
  assign pready      = 1'b1;
  assign in_stall_o  = st_q != ST_IDLE;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = st_q == ST_OUT;
  assign working     = st_q != ST_IDLE && st_q != ST_OUT;

  // Inlet-only draws mass out of the volume; air inflow is signed the same way.
  assign sub_mode = mode_q == MODE_INLET || mode_q == MODE_AIR_IN;

  always_comb begin
    num_add  = sat_add(pres_q, boff_q);
    fy_sub   = sat_sub(t0_q, alu_res);
    rho_arg  = (st_q == ST_AP4) ? t1_q : alu_res;
    rho_upd  = sub_mode ? sat_sub(rho_q, rho_arg) : sat_add(rho_q, rho_arg);
    pres_upd = sub_mode ? sat_sub(pres_q, alu_res) : sat_add(pres_q, alu_res);
    om_mag   = om_q[63] ? 64'd0 - om_q : om_q;
    case (st_q)
      ST_NUM:  extra_sat = num_add[64];
      ST_FY:   extra_sat = fy_sub[64];
      ST_DRHO: extra_sat = rho_upd[64];
      ST_DP:   extra_sat = pres_upd[64];
      ST_AP4:  extra_sat = rho_upd[64] | pres_upd[64];
      default: extra_sat = 1'b0;
    endcase
  end

  // Operand selection for the shared serial unit, one operation per state.
  always_comb begin
    alu_req.start = working && !issued_q;
    alu_req.op    = OP_MUL;
    alu_a         = '0;
    alu_b         = '0;
    case (st_q)
      ST_NUM: begin
        alu_a = {1'b0, gamma_q};
        alu_b = num_add[63:0];
      end
      ST_CDIV: begin
        alu_req.op = OP_DIV;
        alu_a      = t0_q;
        alu_b      = rho_q;
      end
      ST_CSQRT: begin
        alu_req.op = OP_SQRT;
        alu_a      = t0_q;
      end
      ST_C2: begin
        alu_a = snd_q;
        alu_b = snd_q;
      end
      ST_FX: begin
        alu_a = (mode_q == MODE_INLET) ? rho_i_q : rho_o_q;
        alu_b = (mode_q == MODE_INLET) ? q_i_q : q_o_q;
      end
      ST_FY: begin
        alu_a = rho_i_q;
        alu_b = q_i_q;
      end
      ST_FDIV, ST_AR2: begin
        alu_req.op = OP_DIV;
        alu_a      = t0_q;
        alu_b      = {1'b0, vol_q};
      end
      ST_OMEGA: begin
        alu_a = c2_q;
        alu_b = f_q;
      end
      ST_DRHO: begin
        alu_a = f_q;
        alu_b = {1'b0, dt_q};
      end
      ST_DP: begin
        alu_a = om_q;
        alu_b = {1'b0, dt_q};
      end
      ST_STAB: begin
        alu_req.op = OP_DIV;
        alu_a      = ONE_FX;
        alu_b      = om_q;
      end
      ST_AR1: begin
        alu_a = rho_q;
        alu_b = q_i_q;
      end
      ST_AR3, ST_AP4: begin
        alu_a = t0_q;
        alu_b = {1'b0, dt_q};
      end
      ST_AP1: begin
        alu_req.op = OP_DIV;
        alu_a      = q_i_q;
        alu_b      = {1'b0, vol_q};
      end
      ST_AP2: begin
        alu_a = t0_q;
        alu_b = {1'b0, gamma_q};
      end
      ST_AP3: begin
        alu_a = t0_q;
        alu_b = pres_q;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  always_comb begin
    case (paddr[5:3])
      REG_VOLUME:    prdata = {1'b0, vol_q};
      REG_GAMMA:     prdata = {1'b0, gamma_q};
      REG_OFFSET:    prdata = boff_q;
      REG_INIT_RHO:  prdata = {1'b0, init_rho_q};
      REG_INIT_PRES: prdata = init_pres_q;
      default:       prdata = '0;
    endcase
  end

  // Sequencer: each computing state issues one operation, then waits for its result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      issued_q    <= 1'b0;
      sat_q       <= 1'b0;
      vol_q       <= RST_VOLUME;
      gamma_q     <= RST_GAMMA;
      boff_q      <= RST_OFFSET;
      init_rho_q  <= RST_INIT_RHO;
      init_pres_q <= RST_INIT_PRES;
      rho_q       <= {1'b0, RST_INIT_RHO};
      pres_q      <= RST_INIT_PRES;
      snd_q       <= '0;
      stab_q      <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[5:3])
          REG_VOLUME:   vol_q   <= pwdata[62:0];
          REG_GAMMA:    gamma_q <= pwdata[62:0];
          REG_OFFSET:   boff_q  <= pwdata;
          REG_INIT_RHO: begin
            init_rho_q <= pwdata[62:0];
            rho_q      <= {1'b0, pwdata[62:0]};
          end
          REG_INIT_PRES: begin
            init_pres_q <= pwdata;
            pres_q      <= pwdata;
          end
          default: ;
        endcase
      end

      if (alu_req.start) issued_q <= 1'b1;

      if (in_xfer) begin
        mode_q  <= req_type_i;
        rho_o_q <= outlet_density_i;
        q_o_q   <= outlet_flow_i;
        rho_i_q <= inlet_density_i;
        q_i_q   <= inlet_flow_i;
        dt_q    <= time_step_i;
        sat_q   <= 1'b0;
        stab_q  <= '0;
        case (req_type_i)
          MODE_INLET, MODE_OUTLET, MODE_BOTH: st_q <= ST_NUM;
          MODE_AIR_IN, MODE_AIR_OUT:          st_q <= ST_AR1;
          default:                            st_q <= ST_OUT;
        endcase
      end else if (st_q == ST_OUT) begin
        if (!out_stall_i) st_q <= ST_IDLE;
      end else if (working && issued_q && alu_rsp.done) begin
        issued_q <= 1'b0;
        sat_q    <= sat_q | alu_rsp.sat | extra_sat;
        case (st_q)
          ST_NUM: begin
            t0_q <= alu_res;
            // The sound speed is only defined for positive density and stiffness term.
            if (!rho_q[63] && rho_q != 64'd0 && !alu_res[63] && alu_res != 64'd0) begin
              st_q <= ST_CDIV;
            end else begin
              snd_q <= '0;
              st_q  <= ST_C2;
            end
          end
          ST_CDIV: begin
            t0_q <= alu_res;
            st_q <= ST_CSQRT;
          end
          ST_CSQRT: begin
            snd_q <= alu_res;
            st_q  <= ST_C2;
          end
          ST_C2: begin
            c2_q <= alu_res;
            st_q <= ST_FX;
          end
          ST_FX: begin
            t0_q <= alu_res;
            st_q <= (mode_q == MODE_BOTH) ? ST_FY : ST_FDIV;
          end
          ST_FY: begin
            t0_q <= fy_sub[63:0];
            st_q <= ST_FDIV;
          end
          ST_FDIV: begin
            f_q  <= alu_res;
            st_q <= ST_OMEGA;
          end
          ST_OMEGA: begin
            om_q <= alu_res;
            st_q <= ST_DRHO;
          end
          ST_DRHO: begin
            rho_q <= rho_upd[63:0];
            st_q  <= ST_DP;
          end
          ST_DP: begin
            pres_q <= pres_upd[63:0];
            if (om_mag > OMEGA_MIN) begin
              st_q <= ST_STAB;
            end else begin
              stab_q <= STAB_CAP;
              st_q   <= ST_OUT;
            end
          end
          ST_STAB: begin
            stab_q <= alu_res;
            st_q   <= ST_OUT;
          end
          ST_AR1: begin
            t0_q <= alu_res;
            st_q <= ST_AR2;
          end
          ST_AR2: begin
            t0_q <= alu_res;
            st_q <= ST_AR3;
          end
          ST_AR3: begin
            t1_q <= alu_res;
            st_q <= ST_AP1;
          end
          ST_AP1: begin
            t0_q <= alu_res;
            st_q <= ST_AP2;
          end
          ST_AP2: begin
            t0_q <= alu_res;
            st_q <= ST_AP3;
          end
          ST_AP3: begin
            t0_q <= alu_res;
            st_q <= ST_AP4;
          end
          ST_AP4: begin
            // Both air updates use the old density and pressure.
            rho_q  <= rho_upd[63:0];
            pres_q <= pres_upd[63:0];
            st_q   <= ST_OUT;
          end
          default: st_q <= ST_IDLE;
        endcase
      end
    end
  end

  assign density_out_o     = rho_q;
  assign pressure_out_o    = pres_q;
  assign sound_speed_out_o = snd_q[62:0];
  assign stable_step_o     = stab_q;
  assign saturated_o       = sat_q;

endmodule

[rtl/core/lvsu_alu.sv]
// Bit-serial fixed-point multiply, divide and square root unit.
module lvsu_alu import lvsu_pkg::*; #(
  parameter int FRAC_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  alu_req_t    req_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output alu_rsp_t    rsp_o,
  output logic [63:0] res_o
);

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_SQRT,
    A_FIN
  } alu_state_e;

  alu_state_e   ast_q;
  alu_op_e      op_q;
  logic         neg_q;
  logic [6:0]   cnt_q;
  logic [127:0] nb_q;
  logic [65:0]  rem_q;
  logic [63:0]  mc_q;
  logic [63:0]  md_q;
  logic [63:0]  res_q;
  logic         done_q;
  logic         sat_q;

  logic [63:0]  a_mag;
  logic [63:0]  b_mag;
  logic [64:0]  mul_add;
  logic [64:0]  div_sh;
  logic         div_ge;
  logic [64:0]  div_sub;
  logic [67:0]  sq_cand;
  logic [67:0]  sq_trial;
  logic         sq_ge;
  logic [67:0]  sq_sub;
  logic [127:0] prod_sh;
  logic [64:0]  fin_mul;
  logic [64:0]  fin_div;

  // Sign and magnitude to a saturated signed 64-bit value; the top bit flags a clamp.
  function automatic logic [64:0] pack(input logic neg, input logic hi_nz,
                                       input logic [63:0] lo);
    logic [64:0] r;
    if (neg) begin
      if (hi_nz || lo > SIGN_MIN) r = {1'b1, SIGN_MIN};
      else r = {1'b0, 64'd0 - lo};
    end else begin
      if (hi_nz || lo[63]) r = {1'b1, POS_MAX};
      else r = {1'b0, lo};
    end
    return r;
  endfunction

  always_comb begin
    a_mag    = a_i[63] ? 64'd0 - a_i : a_i;
    b_mag    = b_i[63] ? 64'd0 - b_i : b_i;
    mul_add  = {1'b0, nb_q[127:64]} + (mc_q[0] ? {1'b0, md_q} : 65'd0);
    div_sh   = {rem_q[63:0], nb_q[127]};
    div_ge   = div_sh >= {1'b0, md_q};
    div_sub  = div_sh - {1'b0, md_q};
    sq_cand  = {rem_q, nb_q[127:126]};
    sq_trial = {2'b00, mc_q, 2'b01};
    sq_ge    = sq_cand >= sq_trial;
    sq_sub   = sq_cand - sq_trial;
    prod_sh  = nb_q >> FRAC_BITS;
    fin_mul  = pack(neg_q, |prod_sh[127:64], prod_sh[63:0]);
    fin_div  = pack(neg_q, |nb_q[127:64], nb_q[63:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ast_q  <= A_IDLE;
      op_q   <= OP_MUL;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (ast_q)
        A_IDLE: begin
          if (req_i.start) begin
            op_q  <= req_i.op;
            neg_q <= a_i[63] ^ b_i[63];
            case (req_i.op)
              OP_MUL: begin
                nb_q  <= '0;
                mc_q  <= a_mag;
                md_q  <= b_mag;
                cnt_q <= 7'd63;
                ast_q <= A_MUL;
              end
              OP_DIV: begin
                if (b_i == 64'd0) begin
                  res_q  <= (a_i == 64'd0) ? 64'd0 : (a_i[63] ? SIGN_MIN : POS_MAX);
                  sat_q  <= a_i != 64'd0;
                  done_q <= 1'b1;
                end else begin
                  nb_q  <= {64'd0, a_mag} << FRAC_BITS;
                  rem_q <= '0;
                  md_q  <= b_mag;
                  cnt_q <= 7'd127;
                  ast_q <= A_DIV;
                end
              end
              OP_SQRT: begin
                nb_q  <= {64'd0, a_i} << FRAC_BITS;
                rem_q <= '0;
                mc_q  <= '0;
                cnt_q <= 7'd63;
                ast_q <= A_SQRT;
              end
              default: begin
                res_q  <= '0;
                sat_q  <= 1'b0;
                done_q <= 1'b1;
              end
            endcase
          end
        end
        A_MUL: begin
          nb_q  <= {mul_add, nb_q[63:1]};
          mc_q  <= {1'b0, mc_q[63:1]};
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd0) ast_q <= A_FIN;
        end
        A_DIV: begin
          rem_q <= {2'b00, div_ge ? div_sub[63:0] : div_sh[63:0]};
          nb_q  <= {nb_q[126:0], div_ge};
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd0) ast_q <= A_FIN;
        end
        A_SQRT: begin
          rem_q <= sq_ge ? sq_sub[65:0] : sq_cand[65:0];
          mc_q  <= {mc_q[62:0], sq_ge};
          nb_q  <= {nb_q[125:0], 2'b00};
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd0) ast_q <= A_FIN;
        end
        A_FIN: begin
          case (op_q)
            OP_MUL: begin
              res_q <= fin_mul[63:0];
              sat_q <= fin_mul[64];
            end
            OP_DIV: begin
              res_q <= fin_div[63:0];
              sat_q <= fin_div[64];
            end
            default: begin
              res_q <= mc_q;
              sat_q <= 1'b0;
            end
          endcase
          done_q <= 1'b1;
          ast_q  <= A_IDLE;
        end
        default: ast_q <= A_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sat  = sat_q;
  assign res_o      = res_q;

endmodule

[rtl/core/lvsu_checker.sv]
// Port-level checker of the lumped volume state update block and its bind.
module lvsu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] density_out_o
);

  // A result that is held back stays presented, with its density unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(density_out_o))
    else $error("stalled result changed or vanished");

  // No new item is taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

  // An accepted item holds off the input in the cycle that follows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while one is in flight");

  // Once a result has been taken the block is ready for the next transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> !in_stall_o)
    else $error("block not ready after result transfer");

endmodule

bind lumped_volume_state_update lvsu_checker u_lvsu_checker (.*);
